### rtl/srb_pkg.sv
// Shared types and constants for the sinogram rebinner.
package srb_pkg;

   localparam int MAX_OUT_BINS_DEF = 262144;
   localparam int MAX_ZOOM         = 8;

   localparam int SAMPLE_W  = 32;
   localparam int ACC_W     = 41;
   localparam int VALUE_W   = 40;
   localparam int DIM_W     = 10;
   localparam int RAD_W     = 9;
   localparam int ANG_W     = 9;
   localparam int PLANE_W   = 10;
   localparam int ZOOM_W    = 4;
   localparam int SUB_W     = 3;
   localparam int GROUP_W   = 3;
   localparam int PROD_W    = RAD_W + DIM_W;
   localparam int ADDR_FULL_W = PROD_W + 1;
   localparam int CMP_W     = 21;

   localparam int DIV_W     = 11;
   localparam int DIV_LANES = 5;
   localparam int DIV_CNT_W = 4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_RHO_IN    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THETA_IN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANES_IN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RT_ZOOM   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Z_ZOOM    = 3'd4;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_DIV,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                first;
      logic                emit;
      logic                frame_end;
      logic [PLANE_W-1:0]  plane;
      logic [ANG_W-1:0]    angle;
      logic [RAD_W-1:0]    radial;
   } op_type;

   typedef struct packed {
      logic [VALUE_W-1:0] bin_value;
      logic [PLANE_W-1:0] plane;
      logic [ANG_W-1:0]   angle;
      logic [RAD_W-1:0]   radial;
      logic               frame_end;
   } result_type;

endpackage

### rtl/sinogram_3d_rebinner_core.sv
// Sinogram rebinner top level: front end, command queue and accumulator back end.
//
// Takes one sinogram sample per cycle in raster order while req_ready is high, and
// sums each rt_zoom x rt_zoom block over a group of z_zoom planes into one bin of a
// single-plane accumulator RAM; the finished bin is clamped at zero and returned with
// its coordinates. Sustained rate is one sample per clock: the accumulator RAM does one
// read and one write per cycle, with a bypass for back-to-back hits on the same bin. A
// sample passes the classification register, the command queue and the accumulator
// stage before its RAM write; a completed bin enters the result queue on that same edge.
// After reset and after every csr write, req_ready stays low while a one-bit-per-cycle
// divider recomputes the output geometry and the block offsets of the current raster
// position. A four-entry command queue and a four-entry result queue let either side
// stall without losing a transaction.
module sinogram_3d_rebinner_core #(
   parameter int MAX_OUT_BINS = srb_pkg::MAX_OUT_BINS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [srb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [srb_pkg::SAMPLE_W-1:0] req_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [srb_pkg::VALUE_W-1:0]      rsp_bin_value,
   output logic [srb_pkg::PLANE_W-1:0]      rsp_out_plane,
   output logic [srb_pkg::ANG_W-1:0]        rsp_out_angle,
   output logic [srb_pkg::RAD_W-1:0]        rsp_out_radial,
   output logic                             rsp_frame_end
);

   import srb_pkg::*;

   localparam int AW    = (MAX_OUT_BINS > 1) ? $clog2(MAX_OUT_BINS) : 1;
   localparam int CMD_W = AW + $bits(op_type);

   logic                 cmd_push;
   logic                 cmd_pop;
   logic [AW-1:0]        push_addr;
   op_type               push_op;
   logic [CMD_W-1:0]     cmd_head;
   logic [CMD_CNT_W-1:0] cmd_count;
   logic [AW-1:0]        pop_addr;
   op_type               pop_op;

   srb_front #(
      .MAX_OUT_BINS (MAX_OUT_BINS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_sample (req_sample),
      .cmd_count  (cmd_count),
      .cmd_push   (cmd_push),
      .cmd_addr   (push_addr),
      .cmd_op     (push_op)
   );

   srb_queue #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data ({push_addr, push_op}),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .count     (cmd_count)
   );

   assign pop_addr = cmd_head[CMD_W-1 -: AW];
   assign pop_op   = cmd_head[$bits(op_type)-1:0];

   srb_back #(
      .MAX_OUT_BINS (MAX_OUT_BINS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_count      (cmd_count),
      .cmd_pop        (cmd_pop),
      .cmd_addr       (pop_addr),
      .cmd_op         (pop_op),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_bin_value  (rsp_bin_value),
      .rsp_out_plane  (rsp_out_plane),
      .rsp_out_angle  (rsp_out_angle),
      .rsp_out_radial (rsp_out_radial),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

### rtl/srb_ram.sv
// Generic single write, single read RAM with registered read data.
module srb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/srb_queue.sv
// Small register FIFO with occupancy count.
module srb_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic [CW-1:0]    count
);

   logic [WIDTH-1:0] data_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = CW'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = data_ff[rd_ptr_ff];
   assign count    = count_ff;

endmodule

### rtl/srb_front.sv
// Front end: config registers, geometry setup divider, raster counters, bin classification.
module srb_front #(
   parameter int MAX_OUT_BINS = srb_pkg::MAX_OUT_BINS_DEF,
   localparam int AW = (MAX_OUT_BINS > 1) ? $clog2(MAX_OUT_BINS) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [srb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [srb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [srb_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [srb_pkg::CMD_CNT_W-1:0]    cmd_count,
   output logic                             cmd_push,
   output logic [AW-1:0]                    cmd_addr,
   output srb_pkg::op_type                  cmd_op
);

   import srb_pkg::*;

   // config registers
   logic [DIM_W-1:0]  rho_in_ff, theta_in_ff, planes_in_ff;
   logic [ZOOM_W-1:0] rt_zoom_ff, z_zoom_ff;
   logic [DIM_W-1:0]  rho_c, theta_c, planes_c;
   logic [ZOOM_W-1:0] rt_c, zz_c;

   // setup divider
   state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [DIV_W-1:0]   num_ff [DIV_LANES];
   logic [DIV_W-1:0]   num_in [DIV_LANES];
   logic [ZOOM_W-1:0]  rem_ff [DIV_LANES];
   logic [ZOOM_W-1:0]  rem_in [DIV_LANES];
   logic [ZOOM_W-1:0]  lane_div [DIV_LANES];
   logic [ZOOM_W:0]    step_sh [DIV_LANES];
   logic               step_ge [DIV_LANES];
   logic [DIV_W-1:0]   step_num [DIV_LANES];
   logic [ZOOM_W-1:0]  step_rem [DIV_LANES];

   // geometry and raster position
   logic [DIM_W-1:0]   rho_out_ff, rho_out_in;
   logic [DIM_W-1:0]   theta_out_ff, theta_out_in;
   logic [PLANE_W-1:0] planes_out_ff, planes_out_in;
   logic [RAD_W-1:0]   r_ff, r_in, orad_ff, orad_in;
   logic [ANG_W-1:0]   t_ff, t_in, oang_ff, oang_in;
   logic [SUB_W-1:0]   rr_ff, rr_in, tt_ff, tt_in;
   logic [PLANE_W-1:0] p_ff, p_in, opp_ff, opp_in;
   logic [GROUP_W-1:0] pig_ff, pig_in;

   logic               accept;
   logic [DIM_W-1:0]   r_inc, t_inc;
   logic [PLANE_W:0]   p_inc, opp_inc;
   logic [ZOOM_W-1:0]  pig_inc, rr_inc, tt_inc;
   logic               r_wrap, t_wrap, p_wrap, pig_wrap, rr_wrap, tt_wrap;
   logic               last_plane, first, emit, frame_end, in_range;
   logic [PROD_W-1:0]  prod;

   // classification stage
   logic               f1v_ff;
   op_type             f1_op_ff;
   logic               f1_range_ff;
   logic [PROD_W-1:0]  f1_prod_ff;
   logic [ADDR_FULL_W-1:0] addr_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         rho_in_ff    <= DIM_W'(256);
         theta_in_ff  <= DIM_W'(288);
         planes_in_ff <= DIM_W'(207);
         rt_zoom_ff   <= ZOOM_W'(1);
         z_zoom_ff    <= ZOOM_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            CSR_RHO_IN:    rho_in_ff    <= csr_wdata;
            CSR_THETA_IN:  theta_in_ff  <= csr_wdata;
            CSR_PLANES_IN: planes_in_ff <= csr_wdata;
            CSR_RT_ZOOM:   rt_zoom_ff   <= csr_wdata[ZOOM_W-1:0];
            CSR_Z_ZOOM:    z_zoom_ff    <= csr_wdata[ZOOM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rho_c    = (rho_in_ff == '0) ? DIM_W'(1) :
                 (rho_in_ff > DIM_W'(512)) ? DIM_W'(512) : rho_in_ff;
      theta_c  = (theta_in_ff == '0) ? DIM_W'(1) :
                 (theta_in_ff > DIM_W'(512)) ? DIM_W'(512) : theta_in_ff;
      planes_c = (planes_in_ff == '0) ? DIM_W'(1) : planes_in_ff;
      rt_c     = (rt_zoom_ff == '0) ? ZOOM_W'(1) :
                 (rt_zoom_ff > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : rt_zoom_ff;
      zz_c     = (z_zoom_ff == '0) ? ZOOM_W'(1) :
                 (z_zoom_ff > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : z_zoom_ff;
   end

   // one restoring quotient bit per lane per cycle
   always_comb begin
      for (int i = 0; i < DIV_LANES; i++) begin
         lane_div[i] = (i == DIV_LANES - 1) ? zz_c : rt_c;
         step_sh[i]  = {rem_ff[i], num_ff[i][DIV_W-1]};
         step_ge[i]  = step_sh[i] >= {1'b0, lane_div[i]};
         step_rem[i] = step_ge[i] ? ZOOM_W'(step_sh[i] - {1'b0, lane_div[i]})
                                  : step_sh[i][ZOOM_W-1:0];
         step_num[i] = {num_ff[i][DIV_W-2:0], step_ge[i]};
      end
   end

   assign req_ready = (state_ff == ST_RUN) &&
                      ((4'(cmd_count) + 4'(f1v_ff)) < 4'(CMD_DEPTH));
   assign accept    = req_valid && req_ready;

   always_comb begin
      r_inc    = DIM_W'({1'b0, r_ff} + 1'b1);
      t_inc    = DIM_W'({1'b0, t_ff} + 1'b1);
      p_inc    = (PLANE_W + 1)'({1'b0, p_ff} + 1'b1);
      opp_inc  = (PLANE_W + 1)'({1'b0, opp_ff} + 1'b1);
      pig_inc  = ZOOM_W'({1'b0, pig_ff} + 1'b1);
      rr_inc   = ZOOM_W'({1'b0, rr_ff} + 1'b1);
      tt_inc   = ZOOM_W'({1'b0, tt_ff} + 1'b1);
      r_wrap   = r_inc >= rho_c;
      t_wrap   = t_inc >= theta_c;
      p_wrap   = p_inc >= {1'b0, planes_c};
      pig_wrap = pig_inc >= zz_c;
      rr_wrap  = rr_inc >= rt_c;
      tt_wrap  = tt_inc >= rt_c;

      last_plane = pig_wrap || p_wrap;
      first      = (pig_ff == '0) && (tt_ff == '0) && (rr_ff == '0);
      emit       = last_plane && (tt_inc == rt_c) && (rr_inc == rt_c);
      in_range   = ({1'b0, orad_ff} < rho_out_ff) && ({1'b0, oang_ff} < theta_out_ff);
      frame_end  = p_wrap && (opp_inc >= {1'b0, planes_out_ff}) &&
                   (DIM_W'({1'b0, oang_ff} + 1'b1) == theta_out_ff) &&
                   (DIM_W'({1'b0, orad_ff} + 1'b1) == rho_out_ff);
      prod       = PROD_W'(oang_ff) * PROD_W'(rho_out_ff);
   end

   always_comb begin
      state_in      = state_ff;
      div_cnt_in    = div_cnt_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      rho_out_in    = rho_out_ff;
      theta_out_in  = theta_out_ff;
      planes_out_in = planes_out_ff;
      r_in    = r_ff;
      t_in    = t_ff;
      p_in    = p_ff;
      rr_in   = rr_ff;
      tt_in   = tt_ff;
      orad_in = orad_ff;
      oang_in = oang_ff;
      opp_in  = opp_ff;
      pig_in  = pig_ff;

      case (state_ff)
         ST_LOAD: begin
            num_in[0] = DIV_W'(r_ff);
            num_in[1] = DIV_W'(t_ff);
            num_in[2] = DIV_W'(rho_c);
            num_in[3] = DIV_W'(theta_c);
            num_in[4] = DIV_W'(DIV_W'(planes_c) + DIV_W'(zz_c) - 1'b1);
            for (int i = 0; i < DIV_LANES; i++) begin
               rem_in[i] = '0;
            end
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            num_in     = step_num;
            rem_in     = step_rem;
            div_cnt_in = DIV_CNT_W'(div_cnt_ff + 1'b1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               state_in      = ST_RUN;
               orad_in       = step_num[0][RAD_W-1:0];
               rr_in         = step_rem[0][SUB_W-1:0];
               oang_in       = step_num[1][ANG_W-1:0];
               tt_in         = step_rem[1][SUB_W-1:0];
               rho_out_in    = step_num[2][DIM_W-1:0];
               theta_out_in  = step_num[3][DIM_W-1:0];
               planes_out_in = step_num[4][PLANE_W-1:0];
            end
         end
         ST_RUN: begin
            if (accept) begin
               if (!r_wrap) begin
                  r_in = r_inc[RAD_W-1:0];
                  if (rr_wrap) begin
                     rr_in   = '0;
                     orad_in = RAD_W'(orad_ff + 1'b1);
                  end else begin
                     rr_in = rr_inc[SUB_W-1:0];
                  end
               end else begin
                  r_in    = '0;
                  rr_in   = '0;
                  orad_in = '0;
                  if (!t_wrap) begin
                     t_in = t_inc[ANG_W-1:0];
                     if (tt_wrap) begin
                        tt_in   = '0;
                        oang_in = ANG_W'(oang_ff + 1'b1);
                     end else begin
                        tt_in = tt_inc[SUB_W-1:0];
                     end
                  end else begin
                     t_in    = '0;
                     tt_in   = '0;
                     oang_in = '0;
                     p_in    = p_inc[PLANE_W-1:0];
                     if (pig_wrap) begin
                        pig_in = '0;
                        opp_in = opp_inc[PLANE_W-1:0];
                     end else begin
                        pig_in = pig_inc[GROUP_W-1:0];
                     end
                     if (p_wrap) begin
                        p_in   = '0;
                        pig_in = '0;
                        opp_in = '0;
                     end
                  end
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase

      if (csr_we) begin
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         div_cnt_ff    <= '0;
         rho_out_ff    <= '0;
         theta_out_ff  <= '0;
         planes_out_ff <= '0;
         r_ff    <= '0;
         t_ff    <= '0;
         p_ff    <= '0;
         rr_ff   <= '0;
         tt_ff   <= '0;
         orad_ff <= '0;
         oang_ff <= '0;
         opp_ff  <= '0;
         pig_ff  <= '0;
         f1v_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         div_cnt_ff    <= div_cnt_in;
         rho_out_ff    <= rho_out_in;
         theta_out_ff  <= theta_out_in;
         planes_out_ff <= planes_out_in;
         r_ff    <= r_in;
         t_ff    <= t_in;
         p_ff    <= p_in;
         rr_ff   <= rr_in;
         tt_ff   <= tt_in;
         orad_ff <= orad_in;
         oang_ff <= oang_in;
         opp_ff  <= opp_in;
         pig_ff  <= pig_in;
         f1v_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (accept) begin
         f1_op_ff.sample    <= req_sample;
         f1_op_ff.first     <= first;
         f1_op_ff.emit      <= emit;
         f1_op_ff.frame_end <= frame_end;
         f1_op_ff.plane     <= opp_ff;
         f1_op_ff.angle     <= oang_ff;
         f1_op_ff.radial    <= orad_ff;
         f1_range_ff        <= in_range;
         f1_prod_ff         <= prod;
      end
   end

   assign addr_full = ADDR_FULL_W'(f1_prod_ff) + ADDR_FULL_W'(f1_op_ff.radial);
   assign cmd_push  = f1v_ff && f1_range_ff &&
                      (CMP_W'(addr_full) < CMP_W'(MAX_OUT_BINS));
   assign cmd_addr  = addr_full[AW-1:0];
   assign cmd_op    = f1_op_ff;

endmodule

### rtl/srb_back.sv
// Back end: accumulator read-modify-write with forwarding, clamp, result queue.
module srb_back #(
   parameter int MAX_OUT_BINS = srb_pkg::MAX_OUT_BINS_DEF,
   localparam int AW = (MAX_OUT_BINS > 1) ? $clog2(MAX_OUT_BINS) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [srb_pkg::CMD_CNT_W-1:0]  cmd_count,
   output logic                           cmd_pop,
   input  logic [AW-1:0]                  cmd_addr,
   input  srb_pkg::op_type                cmd_op,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [srb_pkg::VALUE_W-1:0]    rsp_bin_value,
   output logic [srb_pkg::PLANE_W-1:0]    rsp_out_plane,
   output logic [srb_pkg::ANG_W-1:0]      rsp_out_angle,
   output logic [srb_pkg::RAD_W-1:0]      rsp_out_radial,
   output logic                           rsp_frame_end
);

   import srb_pkg::*;

   logic              b1v_ff;
   op_type            b1_op_ff;
   logic [AW-1:0]     b1_addr_ff;
   logic              last_v_ff;
   logic [AW-1:0]     last_addr_ff;
   logic [ACC_W-1:0]  last_acc_ff;

   logic [ACC_W-1:0]  rd_data;
   logic [ACC_W-1:0]  base;
   logic [ACC_W-1:0]  sample_ext;
   logic [ACC_W-1:0]  acc;

   logic [OUT_CNT_W-1:0] out_count;
   logic              out_pop;
   result_type        out_push_data;
   result_type        out_head;

   assign cmd_pop = (cmd_count != '0) &&
                    ((4'(out_count) + 4'(b1v_ff)) < 4'(OUT_DEPTH));

   srb_ram #(
      .WIDTH (ACC_W),
      .DEPTH (MAX_OUT_BINS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (b1v_ff),
      .wr_addr (b1_addr_ff),
      .wr_data (acc),
      .rd_addr (cmd_addr),
      .rd_data (rd_data)
   );

   // the previous write lands on the same edge as this read; take it from the bypass
   always_comb begin
      base       = (last_v_ff && (last_addr_ff == b1_addr_ff)) ? last_acc_ff : rd_data;
      sample_ext = {{(ACC_W - SAMPLE_W){b1_op_ff.sample[SAMPLE_W-1]}}, b1_op_ff.sample};
      acc        = b1_op_ff.first ? sample_ext : ACC_W'(base + sample_ext);

      out_push_data.bin_value = acc[ACC_W-1] ? '0 : acc[VALUE_W-1:0];
      out_push_data.plane     = b1_op_ff.plane;
      out_push_data.angle     = b1_op_ff.angle;
      out_push_data.radial    = b1_op_ff.radial;
      out_push_data.frame_end = b1_op_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1v_ff    <= 1'b0;
         last_v_ff <= 1'b0;
      end else begin
         b1v_ff    <= cmd_pop;
         last_v_ff <= b1v_ff;
      end
   end

   always_ff @(posedge clock) begin
      b1_op_ff     <= cmd_op;
      b1_addr_ff   <= cmd_addr;
      last_addr_ff <= b1_addr_ff;
      last_acc_ff  <= acc;
   end

   srb_queue #(
      .WIDTH ($bits(result_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (b1v_ff && b1_op_ff.emit),
      .push_data (out_push_data),
      .pop       (out_pop),
      .pop_data  (out_head),
      .count     (out_count)
   );

   assign rsp_valid      = out_count != '0;
   assign out_pop        = rsp_valid && rsp_ready;
   assign rsp_bin_value  = out_head.bin_value;
   assign rsp_out_plane  = out_head.plane;
   assign rsp_out_angle  = out_head.angle;
   assign rsp_out_radial = out_head.radial;
   assign rsp_frame_end  = out_head.frame_end;

endmodule
